// ===== sv/sslc_pkg.sv =====
// Shared types, character constants and method keyword tables for the start-line classifier.
package sslc_pkg;

    // Fixed field widths
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned CODE_W   = 10;
    localparam int unsigned METH_W   = 3;
    localparam int unsigned CHAR_W   = 4;
    localparam int unsigned DCNT_W   = 2;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned NUM_DIGITS = 3;
    localparam int unsigned NUM_METHODS = 6;

    // Method codes
    localparam logic [METH_W-1:0] METH_REGISTER = 3'd0;
    localparam logic [METH_W-1:0] METH_INVITE   = 3'd1;
    localparam logic [METH_W-1:0] METH_ACK      = 3'd2;
    localparam logic [METH_W-1:0] METH_CANCEL   = 3'd3;
    localparam logic [METH_W-1:0] METH_BYE      = 3'd4;
    localparam logic [METH_W-1:0] METH_OPTIONS  = 3'd5;
    localparam logic [METH_W-1:0] METH_NONE     = 3'd6;

    // Characters of interest
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [DIGIT_W-1:0] DIGIT_TWO = 4'd2;
    localparam logic [DCNT_W-1:0]  DCNT_FULL = 2'd3;

    // One classified start line, line_valid in bit 0
    typedef struct packed {
        logic [LEN_W-1:0]  start_line_length;
        logic              is_success;
        logic [CODE_W-1:0] response_code;
        logic [METH_W-1:0] method_code;
        logic              is_request;
        logic              line_valid;
    } t_result;

    // Keyword length of a method
    function automatic logic [CHAR_W-1:0] method_len(input logic [METH_W-1:0] m);
        logic [CHAR_W-1:0] len;
        unique case (m)
            METH_REGISTER: len = 4'd8;
            METH_INVITE:   len = 4'd6;
            METH_ACK:      len = 4'd3;
            METH_CANCEL:   len = 4'd6;
            METH_BYE:      len = 4'd3;
            METH_OPTIONS:  len = 4'd7;
            default:       len = 4'd0;
        endcase
        return len;
    endfunction

    // Letter at position pos of a method keyword, zero past its end
    function automatic logic [7:0] method_char(input logic [METH_W-1:0] m,
                                               input logic [2:0] pos);
        logic [63:0] text;
        unique case (m)
            METH_REGISTER: text = "RETSIGER";
            METH_INVITE:   text = {16'h0, "ETIVNI"};
            METH_ACK:      text = {40'h0, "KCA"};
            METH_CANCEL:   text = {16'h0, "LECNAC"};
            METH_BYE:      text = {40'h0, "EYB"};
            METH_OPTIONS:  text = {8'h0, "SNOITPO"};
            default:       text = 64'h0;
        endcase
        return text[pos*8 +: 8];
    endfunction

endpackage

// ===== sv/sip_start_line_classifier_top.sv =====
// Top level of the SIP start-line classifier: byte stream in, one result beat per message out.
//
// Usage:
//   Slave stream carries one message byte per beat in s_tdata; s_tlast marks
//   the final byte of the message. Every byte beat is consumed; only the
//   tlast beat produces a result.
//   Master stream carries one 32-bit result beat per message: validity, kind,
//   method, response code, success flag and start-line length.
//   Throughput is one byte per cycle while s_tready is high. The per-byte match
//   and digit logic sits between the parse state registers and the output
//   stage, so a result is registered there as its tlast beat is accepted.
//   A two-entry output stage (result register plus skid) parts the channels:
//   s_tready drops only when both entries are full, i.e. the receiver has
//   stalled on two pending results; byte beats between results keep flowing
//   while one result waits.
//   Reset (synchronous, active low) clears the parse state and empties the
//   output stage; the block is ready in the first cycle after reset.
module sip_start_line_classifier_top #(
    parameter int unsigned MAX_MESSAGE_BYTES = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] line_valid, [1] is_request, [4:2] method_code, [14:5] response_code,
    // [15] is_success, [31:16] start_line_length
    output logic [31:0] m_tdata
);

    logic              beat_valid;
    logic              res_valid;
    logic              res_ready;
    sslc_pkg::t_result res_data;
    sslc_pkg::t_result out_data;

    assign beat_valid = s_tvalid && s_tready;
    assign s_tready   = res_ready;

    // Parse bytes into a result on the last beat
    sslc_parser #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat_valid(beat_valid),
        .i_data_byte (s_tdata),
        .i_last_byte (s_tlast),
        .o_res_valid (res_valid),
        .o_result    (res_data)
    );

    // Register results toward the receiver
    sslc_out_skid u_out_skid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(res_valid),
        .i_data (res_data),
        .o_ready(res_ready),
        .o_valid(m_tvalid),
        .o_data (out_data),
        .i_ready(m_tready)
    );

    assign m_tdata = out_data;

`ifndef SYNTH
    // An empty output register implies the skid entry is empty too
    a_skid_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid |-> s_tready)
        else $error("skid entry held while output register empty");

    // An invalid line reports no method, code or length
    a_invalid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !out_data.line_valid) |->
            (out_data.method_code == sslc_pkg::METH_NONE && out_data.response_code == '0
             && out_data.start_line_length == '0 && !out_data.is_request))
        else $error("invalid result carries payload");

    // A request carries a real method and no response data
    a_request_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && out_data.is_request) |->
            (out_data.method_code != sslc_pkg::METH_NONE && out_data.response_code == '0
             && !out_data.is_success))
        else $error("request result has response fields");

    // Success only for a valid response with a 2xx code
    a_success_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && out_data.is_success) |->
            (out_data.line_valid && !out_data.is_request
             && out_data.response_code >= 10'd200 && out_data.response_code <= 10'd299))
        else $error("success flag without a 2xx response");
`endif

endmodule

// ===== sv/sslc_parser.sv =====
// Per-byte start-line parser: match state, digit capture, length count and result build.
module sslc_parser #(
    parameter int unsigned MAX_MESSAGE_BYTES = 65535
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_beat_valid,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_res_valid,
    output sslc_pkg::t_result    o_result
);

    localparam logic [2:0] PH_METHOD     = 3'd0;
    localparam logic [2:0] PH_REQ_SKIP   = 3'd1;
    localparam logic [2:0] PH_SEEK_SPACE = 3'd2;
    localparam logic [2:0] PH_DIGITS     = 3'd3;
    localparam logic [2:0] PH_RESP_SKIP  = 3'd4;
    localparam logic [2:0] PH_DONE       = 3'd5;
    localparam logic [2:0] PH_FAIL       = 3'd6;

    localparam logic [1:0] FLAG_VALID   = 2'b01;
    localparam logic [1:0] FLAG_REQUEST = 2'b10;

    localparam logic [sslc_pkg::LEN_W-1:0] LEN_MAX = sslc_pkg::LEN_W'(MAX_MESSAGE_BYTES);

    logic [2:0]                        r_phase, n_phase;
    logic [sslc_pkg::METH_W-1:0]       r_method, n_method;
    logic [sslc_pkg::CHAR_W-1:0]       r_char, n_char;
    logic [sslc_pkg::DCNT_W-1:0]       r_dcnt, n_dcnt;
    logic [sslc_pkg::DIGIT_W-1:0]      r_dig [sslc_pkg::NUM_DIGITS];
    logic [sslc_pkg::DIGIT_W-1:0]      n_dig [sslc_pkg::NUM_DIGITS];
    logic [sslc_pkg::LEN_W-1:0]        r_len, n_len;
    logic [1:0]                        r_flags, n_flags;

    logic       count_en;
    logic       found;
    logic [1:0] fin_flags;
    logic       fin_valid;
    logic       fin_req;
    logic       is_digit;

    assign is_digit = (i_data_byte >= sslc_pkg::CH_ZERO) && (i_data_byte <= sslc_pkg::CH_NINE);

    // Advance the parse state by one byte
    always_comb begin
        n_phase  = r_phase;
        n_method = r_method;
        n_char   = r_char;
        n_dcnt   = r_dcnt;
        n_dig    = r_dig;
        n_flags  = r_flags;
        count_en = 1'b0;
        found    = 1'b0;
        unique case (r_phase)
            PH_METHOD: begin
                count_en = 1'b1;
                if (i_data_byte == sslc_pkg::CH_LF) begin
                    n_phase = PH_DONE;
                    n_flags = FLAG_VALID | FLAG_REQUEST;
                end else if (r_char >= sslc_pkg::method_len(r_method)) begin
                    n_phase = PH_REQ_SKIP;
                end else if (i_data_byte == sslc_pkg::method_char(r_method, r_char[2:0])) begin
                    n_char = r_char + 1'b1;
                end else begin
                    // Restart on the first later method whose first letter matches
                    for (int k = 0; k < sslc_pkg::NUM_METHODS; k++) begin
                        if (!found && (k > int'(r_method)) &&
                            (i_data_byte == sslc_pkg::method_char(
                                sslc_pkg::METH_W'(k), 3'd0))) begin
                            found    = 1'b1;
                            n_method = sslc_pkg::METH_W'(k);
                        end
                    end
                    if (found) begin
                        n_char = 4'd1;
                    end else begin
                        n_method = sslc_pkg::METH_NONE;
                        n_char   = 4'd0;
                        n_phase  = (i_data_byte == sslc_pkg::CH_SP) ? PH_DIGITS
                                                                     : PH_SEEK_SPACE;
                    end
                end
            end
            PH_REQ_SKIP: begin
                count_en = 1'b1;
                if (i_data_byte == sslc_pkg::CH_LF) begin
                    n_phase = PH_DONE;
                    n_flags = FLAG_VALID | FLAG_REQUEST;
                end
            end
            PH_SEEK_SPACE: begin
                count_en = 1'b1;
                if (i_data_byte == sslc_pkg::CH_SP) begin
                    n_phase = PH_DIGITS;
                end
            end
            PH_DIGITS: begin
                if (i_data_byte == sslc_pkg::CH_SP) begin
                    count_en = 1'b1;
                    n_phase  = PH_RESP_SKIP;
                end else if ((r_dcnt == sslc_pkg::DCNT_FULL) || !is_digit) begin
                    n_phase = PH_FAIL;
                end else begin
                    count_en = 1'b1;
                    n_dcnt   = r_dcnt + 1'b1;
                    case (r_dcnt)
                        2'd0:    n_dig[0] = i_data_byte[3:0];
                        2'd1:    n_dig[1] = i_data_byte[3:0];
                        default: n_dig[2] = i_data_byte[3:0];
                    endcase
                end
            end
            PH_RESP_SKIP: begin
                count_en = 1'b1;
                if (i_data_byte == sslc_pkg::CH_LF) begin
                    n_phase = PH_DONE;
                    n_flags = FLAG_VALID;
                end
            end
            default: begin
            end
        endcase
        n_len = (count_en && (r_len < LEN_MAX)) ? r_len + 1'b1 : r_len;
    end

    // Build the result from the state after this byte
    always_comb begin
        unique case (n_phase)
            PH_METHOD, PH_REQ_SKIP: fin_flags = FLAG_VALID | FLAG_REQUEST;
            PH_RESP_SKIP:           fin_flags = FLAG_VALID;
            PH_DONE:                fin_flags = n_flags;
            default:                fin_flags = 2'b00;
        endcase
        fin_valid = fin_flags[0];
        fin_req   = fin_valid && fin_flags[1];
        o_result.line_valid  = fin_valid;
        o_result.is_request  = fin_req;
        o_result.method_code = fin_req ? n_method : sslc_pkg::METH_NONE;
        o_result.response_code = (fin_valid && !fin_req)
            ? (sslc_pkg::CODE_W'(n_dig[0]) * 10'd100 + sslc_pkg::CODE_W'(n_dig[1]) * 10'd10
               + sslc_pkg::CODE_W'(n_dig[2]))
            : '0;
        o_result.is_success = fin_valid && !fin_req && (n_dcnt != 2'd0)
                              && (n_dig[0] == sslc_pkg::DIGIT_TWO);
        o_result.start_line_length = fin_valid ? n_len : '0;
    end

    assign o_res_valid = i_beat_valid && i_last_byte;

    // Hold state; clear it after the last beat of a message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_beat_valid && i_last_byte)) begin
            r_phase  <= PH_METHOD;
            r_method <= sslc_pkg::METH_REGISTER;
            r_char   <= '0;
            r_dcnt   <= '0;
            r_dig    <= '{default: '0};
            r_len    <= '0;
            r_flags  <= '0;
        end else if (i_beat_valid) begin
            r_phase  <= n_phase;
            r_method <= n_method;
            r_char   <= n_char;
            r_dcnt   <= n_dcnt;
            r_dig    <= n_dig;
            r_len    <= n_len;
            r_flags  <= n_flags;
        end
    end

endmodule

// ===== sv/sslc_out_skid.sv =====
// Result register with one skid entry between the parser and the output stream.
module sslc_out_skid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  sslc_pkg::t_result    i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    output sslc_pkg::t_result    o_data,
    input  logic                 i_ready
);

    logic              r_out_valid;
    logic              r_skid_valid;
    sslc_pkg::t_result r_out_data;
    sslc_pkg::t_result r_skid_data;
    logic              push;
    logic              pop;

    assign o_ready = !r_skid_valid;
    assign push    = i_valid && !r_skid_valid;
    assign pop     = r_out_valid && i_ready;

    // Control: refill from skid first, else take the new beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out_data <= r_skid_data;
            end
        end else if (push) begin
            if (r_out_valid && !pop) begin
                r_skid_data <= i_data;
            end else begin
                r_out_data <= i_data;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule
